@@ src/i2crtm_pkg.sv @@
// ============================================================================
// i2crtm_pkg
// Types and constants for the I2C register transaction master.
// ============================================================================
package i2crtm_pkg;

  // Largest number of data bytes in one transaction
  localparam int MaxBytes = 2;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_WR_ADDR = 2'd0;
  localparam logic [1:0] CFG_RD_ADDR = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  // Configuration reset values
  localparam logic [7:0] WR_ADDR_RST = 8'd108;
  localparam logic [7:0] RD_ADDR_RST = 8'd109;
  localparam logic [9:0] TIMEOUT_RST = 10'd250;

  // Bus sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_SEND,
    PH_ACKWAIT,
    PH_RSETUP,
    PH_READ,
    PH_ACKOUT,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [7:0] wr_addr;
    logic [7:0] rd_addr;
    logic [9:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic       req_valid;
    logic       req_type;
    logic [7:0] reg_index;
    logic [1:0] byte_count;
    logic [7:0] wr_first_byte;
    logic [7:0] wr_second_byte;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_drive_enable;
    logic        busy_res;
    logic        done_res;
    logic        nack_seen;
    logic [15:0] rd_data;
  } out_t;

  // Sequencer state, including the held request
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  tick;
    logic [3:0]  bit_cnt;
    logic [2:0]  byte_idx;
    logic [7:0]  shift;
    logic [9:0]  ack_wait;
    logic [15:0] accum;
    logic [7:0]  reg_index;
    logic [7:0]  wr_first;
    logic [7:0]  wr_second;
    logic        is_write;
    logic [1:0]  count;
    logic        fail;
  } state_t;

endpackage

@@ src/i2crtm_step.sv @@
// ============================================================================
// i2crtm_step
// One bus tick of the sequencer: next state and line levels from the
// current state, the configuration and one input transaction.
// ============================================================================
module i2crtm_step (
  input  i2crtm_pkg::state_t cur,
  input  i2crtm_pkg::cfg_t   cfg,
  input  i2crtm_pkg::in_t    din,
  output i2crtm_pkg::state_t nxt,
  output i2crtm_pkg::out_t   dout
);

  // Load a byte into the shifter and start sending it
  function automatic i2crtm_pkg::state_t begin_send(i2crtm_pkg::state_t st,
                                                    logic [7:0] b);
    i2crtm_pkg::state_t r;
    r         = st;
    r.shift   = b;
    r.bit_cnt = 4'd0;
    r.tick    = 3'd0;
    r.phase   = i2crtm_pkg::PH_SEND;
    return r;
  endfunction

  always_comb begin
    i2crtm_pkg::state_t s;
    logic [1:0] cnt;
    logic       last;
    logic [7:0] nb;
    logic [3:0] bit_inc;

    s    = cur;
    dout = '0;
    dout.scl_level        = 1'b1;
    dout.sda_level        = 1'b1;
    dout.sda_drive_enable = 1'b1;
    dout.busy_res         = 1'b1;

    // Take a new request when idle; count saturates to 1..MaxBytes
    cnt = din.byte_count;
    if (cnt == 2'd0) begin
      cnt = 2'd1;
    end else if (cnt > 2'(i2crtm_pkg::MaxBytes)) begin
      cnt = 2'(i2crtm_pkg::MaxBytes);
    end
    if (cur.phase == i2crtm_pkg::PH_IDLE && din.req_valid) begin
      s           = '0;
      s.phase     = i2crtm_pkg::PH_START;
      s.reg_index = din.reg_index;
      s.wr_first  = din.wr_first_byte;
      s.wr_second = din.wr_second_byte;
      s.is_write  = din.req_type;
      s.count     = cnt;
    end

    last    = (s.byte_idx - 3'd2) >= {1'b0, s.count};
    nb      = '0;
    bit_inc = s.bit_cnt + 4'd1;

    case (s.phase)
      i2crtm_pkg::PH_START: begin
        dout.sda_level = (s.tick < 3'd4);
        if (s.tick >= 3'd7) begin
          s = begin_send(s, (s.byte_idx == 3'd0) ? cfg.wr_addr : cfg.rd_addr);
        end else begin
          s.tick = s.tick + 3'd1;
        end
      end
      i2crtm_pkg::PH_SEND: begin
        dout.scl_level = (s.tick >= 3'd2);
        dout.sda_level = s.shift[7];
        if (s.tick >= 3'd3) begin
          s.shift   = {s.shift[6:0], 1'b0};
          s.bit_cnt = bit_inc;
          s.tick    = 3'd0;
          if (bit_inc >= 4'd8) begin
            s.phase    = i2crtm_pkg::PH_ACKWAIT;
            s.ack_wait = 10'd0;
          end
        end else begin
          s.tick = s.tick + 3'd1;
        end
      end
      i2crtm_pkg::PH_ACKWAIT: begin
        dout.sda_drive_enable = 1'b0;
        dout.scl_level        = (s.tick >= 3'd1);
        if (s.tick < 3'd2) begin
          s.tick = s.tick + 3'd1;
        end else if (!din.sda_in) begin
          // Acknowledged: pick the next step of the transaction
          s.tick = 3'd0;
          if (s.byte_idx == 3'd0) begin
            s.byte_idx = 3'd1;
            s = begin_send(s, s.reg_index);
          end else if (s.byte_idx == 3'd1) begin
            s.byte_idx = 3'd2;
            if (s.is_write) begin
              s = begin_send(s, s.wr_first);
            end else begin
              s.phase = i2crtm_pkg::PH_RSETUP;
            end
          end else if (s.is_write) begin
            if ((s.byte_idx - 3'd1) < {1'b0, s.count}) begin
              nb = ((s.byte_idx - 3'd1) == 3'd1) ? s.wr_second : 8'h00;
              s.byte_idx = s.byte_idx + 3'd1;
              s = begin_send(s, nb);
            end else begin
              s.phase = i2crtm_pkg::PH_STOP;
            end
          end else begin
            s.byte_idx = 3'd3;
            s.bit_cnt  = 4'd0;
            s.shift    = 8'h00;
            s.phase    = i2crtm_pkg::PH_READ;
          end
        end else if (s.ack_wait >= cfg.timeout) begin
          // Acknowledge timed out
          s.fail  = 1'b1;
          s.phase = i2crtm_pkg::PH_STOP;
          s.tick  = 3'd0;
        end else begin
          s.ack_wait = s.ack_wait + 10'd1;
        end
      end
      i2crtm_pkg::PH_RSETUP: begin
        dout.scl_level = 1'b0;
        if (s.tick >= 3'd1) begin
          s.phase = i2crtm_pkg::PH_START;
          s.tick  = 3'd0;
        end else begin
          s.tick = s.tick + 3'd1;
        end
      end
      i2crtm_pkg::PH_READ: begin
        dout.sda_drive_enable = 1'b0;
        dout.scl_level        = (s.tick >= 3'd2);
        if (s.tick >= 3'd3) begin
          s.shift   = {s.shift[6:0], din.sda_in};
          s.bit_cnt = bit_inc;
          s.tick    = 3'd0;
          if (bit_inc >= 4'd8) begin
            s.phase = i2crtm_pkg::PH_ACKOUT;
          end
        end else begin
          s.tick = s.tick + 3'd1;
        end
      end
      i2crtm_pkg::PH_ACKOUT: begin
        // ACK every byte but the last, which gets NACK
        dout.scl_level = (s.tick >= 3'd2);
        dout.sda_level = last;
        if (s.tick >= 3'd3) begin
          s.accum = {s.accum[7:0], s.shift};
          s.tick  = 3'd0;
          if (last) begin
            if (s.count == 2'd1) begin
              s.accum = {s.shift, 8'h00};
            end
            s.phase = i2crtm_pkg::PH_STOP;
          end else begin
            s.byte_idx = s.byte_idx + 3'd1;
            s.bit_cnt  = 4'd0;
            s.shift    = 8'h00;
            s.phase    = i2crtm_pkg::PH_READ;
          end
        end else begin
          s.tick = s.tick + 3'd1;
        end
      end
      i2crtm_pkg::PH_STOP: begin
        dout.scl_level = (s.tick >= 3'd4);
        dout.sda_level = (s.tick >= 3'd6);
        if (s.tick >= 3'd7) begin
          dout.busy_res  = 1'b0;
          dout.done_res  = 1'b1;
          dout.nack_seen = s.fail;
          dout.rd_data   = s.is_write ? 16'h0000 : s.accum;
          s.phase        = i2crtm_pkg::PH_IDLE;
          s.tick         = 3'd0;
        end else begin
          s.tick = s.tick + 3'd1;
        end
      end
      default: begin
        s.phase       = i2crtm_pkg::PH_IDLE;
        dout.busy_res = 1'b0;
      end
    endcase

    nxt = s;
  end

endmodule

@@ src/i2c_register_transaction_master.sv @@
// ============================================================================
// i2c_register_transaction_master
// I2C master running one register read or write per request, one bus tick
// per input transaction.
// ============================================================================
// Usage:
//   Each slave-side transaction is one bus tick: it carries the request
//   fields (taken only while idle) and the sampled SDA level. Each accepted
//   tick yields exactly one master-side transaction with the SCL/SDA levels,
//   the SDA drive enable, busy, done, the NACK flag and the read data.
//   Config writes (index 0 write address byte, 1 read address byte,
//   2 ACK timeout) are always accepted; indexes beyond the list are ignored.
//   Output: registered; a tick's result shows in the cycle after acceptance.
//   Throughput: one tick per cycle unless stalled; each sequencer state
//   update is one combinational pass between the state and output registers.
//   Stall: while the output register holds an untaken result, s_tready is low
//   unless m_tready takes it in the same cycle.
//   Reset: sequencer idle, no result pending, config registers at defaults.
// ============================================================================
module i2c_register_transaction_master (
  input  logic        clk,
  input  logic        rst,
  // Bus tick in
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_valid[0], reg_index[8:1], byte_count[10:9], wr_first_byte[18:11],
  // wr_second_byte[26:19], sda_in[27], zero[31:28]
  input  logic [31:0] s_tdata,
  // req_type[0]
  input  logic        s_tuser,
  // Line levels and status out
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl_level[0], sda_level[1], sda_drive_enable[2], busy_res[3],
  // done_res[4], nack_seen[5], rd_data[21:6], zero[23:22]
  output logic [23:0] m_tdata,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  i2crtm_pkg::cfg_t   cfg;
  i2crtm_pkg::state_t state;
  i2crtm_pkg::state_t state_next;
  i2crtm_pkg::in_t    din;
  i2crtm_pkg::out_t   dout;
  i2crtm_pkg::out_t   out_reg;
  logic               s_fire;

  // Unpack the input transaction
  assign din.req_valid      = s_tdata[0];
  assign din.req_type       = s_tuser;
  assign din.reg_index      = s_tdata[8:1];
  assign din.byte_count     = s_tdata[10:9];
  assign din.wr_first_byte  = s_tdata[18:11];
  assign din.wr_second_byte = s_tdata[26:19];
  assign din.sda_in         = s_tdata[27];

  assign s_tready  = !m_tvalid || m_tready;
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wr_addr <= i2crtm_pkg::WR_ADDR_RST;
      cfg.rd_addr <= i2crtm_pkg::RD_ADDR_RST;
      cfg.timeout <= i2crtm_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        i2crtm_pkg::CFG_WR_ADDR: cfg.wr_addr <= cfg_data[7:0];
        i2crtm_pkg::CFG_RD_ADDR: cfg.rd_addr <= cfg_data[7:0];
        i2crtm_pkg::CFG_TIMEOUT: cfg.timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  i2crtm_step u_step (
    .cur  (state),
    .cfg  (cfg),
    .din  (din),
    .nxt  (state_next),
    .dout (dout)
  );

  // Sequencer state register; all zero is the idle phase
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s_fire) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_reg <= dout;
    end
  end

  assign m_tdata = {2'b00, out_reg.rd_data, out_reg.nack_seen, out_reg.done_res,
                    out_reg.busy_res, out_reg.sda_drive_enable, out_reg.sda_level,
                    out_reg.scl_level};

endmodule

@@ src/i2crtm_checker.sv @@
// ============================================================================
// i2crtm_checker
// Port-level checks of the I2C register transaction master.
// ============================================================================
module i2crtm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // An accepted tick always yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted tick produced no result");

  // Input is held off only by a stalled pending result
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a pending result");

  // No result pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result pending after reset");

  // A stalled result holds its payload
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Done ticks never report busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> !m_tdata[3])
    else $error("done reported with busy");

endmodule

bind i2c_register_transaction_master i2crtm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
